[rtl/ordered_list_insert_delete_search_macros.svh]
// Assertion macros for the ordered list block.
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

`ifndef SYNTH
`define OLIST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("olist assertion failed");
`define OLIST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("olist assertion failed");
`else
`define OLIST_ASSERT(lbl, prop)
`define OLIST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/olist_pkg.sv]
// Shared constants and types of the ordered list block.
package olist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Command broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic              act;
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  cnt;
  } cell_cmd_t;

endpackage

[rtl/olist_cell.sv]
// One list cell: holds an entry, shifts with its neighbors, compares for search.
module olist_cell import olist_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] prev_entry_i,
  input  logic [DATA_W-1:0] next_entry_i,
  output logic [DATA_W-1:0] entry_o,
  output logic              match_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              match_q, match_d;
  logic [POS_W-1:0]  idx_ext;

  assign idx_ext = POS_W'(cell_idx_i);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (idx_ext > cmd_i.pos) begin
        entry_d = prev_entry_i;
      end else if (idx_ext == cmd_i.pos) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.del && (idx_ext >= cmd_i.pos)) begin
      entry_d = next_entry_i;
    end
  end

  // only cells below the fill count take part in a search
  assign match_d = (entry_q == cmd_i.value) && (CNT_W'(cell_idx_i) < cmd_i.cnt);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmd_i.act) begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

[rtl/ordered_list_insert_delete_search.sv]
// Ordered list of up to 16 signed 32-bit values kept in a chain of cells.
// Items go through capture, cell execute and match encode, then the output register;
// a new item is accepted only once the last has left the encode stage;
// the execute cycle shifts or compares all cells at once.
// Reset: list count clears to zero, all stages empty; cell entries are not reset.
`include "ordered_list_insert_delete_search_macros.svh"

module ordered_list_insert_delete_search import olist_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [3:0]         found_position_o,
  output logic [CNT_W-1:0]   entry_count_o
);

  // capture stage
  logic              op_vld_q;
  logic [1:0]        func_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  count_q, count_d;

  // encode stage
  logic              enc_vld_q;
  logic              enc_srch_q;
  logic [1:0]        enc_status_q, enc_status_d;
  logic [CNT_W-1:0]  enc_count_q;

  // output register
  logic              out_vld_q;
  logic [1:0]        out_status_q;
  logic [3:0]        out_found_q;
  logic [CNT_W-1:0]  out_count_q;

  logic              in_acc;
  logic              enc_move;
  logic              ins_range, is_full, ins_ok, del_ok;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic              hit;
  logic [IDX_W-1:0]  first_idx;
  logic [1:0]        fin_status;
  logic [3:0]        fin_found;

  assign in_stall_o = op_vld_q | enc_vld_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign enc_move   = enc_vld_q & (~out_vld_q | ~out_stall_i);

  // execute-cycle decisions on the count before the update
  assign ins_range = pos_q > POS_W'(count_q);
  assign is_full   = count_q == CNT_W'(CAPACITY);
  assign ins_ok    = op_vld_q && (func_q == FUNC_INSERT) && !ins_range && !is_full;
  assign del_ok    = op_vld_q && (func_q == FUNC_DELETE) && (pos_q < POS_W'(count_q));

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (del_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    case (func_q)
      FUNC_INSERT: enc_status_d = ins_range ? ST_RANGE : (is_full ? ST_FULL : ST_OK);
      FUNC_DELETE: enc_status_d = del_ok ? ST_OK : ST_RANGE;
      FUNC_SEARCH: enc_status_d = ST_OK;
      default:     enc_status_d = ST_RANGE;
    endcase
  end

  assign cmd.act   = op_vld_q;
  assign cmd.ins   = ins_ok;
  assign cmd.del   = del_ok;
  assign cmd.pos   = pos_q;
  assign cmd.value = val_q;
  assign cmd.cnt   = count_q;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [DATA_W-1:0] prev_e, next_e;
    if (gi == 0) begin : g_first
      assign prev_e = val_q;
    end else begin : g_prev
      assign prev_e = entries[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign next_e = entries[gi];
    end else begin : g_next
      assign next_e = entries[gi+1];
    end
    olist_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (IDX_W'(gi)),
      .cmd_i        (cmd),
      .prev_entry_i (prev_e),
      .next_entry_i (next_e),
      .entry_o      (entries[gi]),
      .match_o      (match[gi])
    );
  end

  // lowest matching cell wins
  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign hit        = |match;
  assign fin_status = enc_srch_q ? (hit ? ST_OK : ST_NOTFOUND) : enc_status_q;
  assign fin_found  = (enc_srch_q && hit) ? 4'(first_idx) : 4'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_vld_q  <= 1'b0;
      enc_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= '0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        op_vld_q <= 1'b1;
      end else if (op_vld_q) begin
        op_vld_q <= 1'b0;
      end
      if (op_vld_q) begin
        enc_vld_q <= 1'b1;
      end else if (enc_move) begin
        enc_vld_q <= 1'b0;
      end
      if (enc_move) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      pos_q  <= position_i;
      val_q  <= item_value_i;
    end
    if (op_vld_q) begin
      enc_srch_q   <= func_q == FUNC_SEARCH;
      enc_status_q <= enc_status_d;
      enc_count_q  <= count_d;
    end
    if (enc_move) begin
      out_status_q <= fin_status;
      out_found_q  <= fin_found;
      out_count_q  <= enc_count_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign entry_count_o    = out_count_q;

  `OLIST_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY))
  `OLIST_ASSERT(a_one_in_flight, !(op_vld_q && enc_vld_q))
  `OLIST_ASSERT_NEXT(a_count_only_on_exec, !op_vld_q, $stable(count_q))
  `OLIST_ASSERT(a_found_means_ok, !(out_vld_q && (out_found_q != 4'd0)) || (out_status_q == ST_OK))

endmodule

[bench/ordered_list_insert_delete_search_tb.sv]
// Self-checking testbench for the ordered list block: directed table, then random traffic.
module ordered_list_insert_delete_search_tb import olist_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       found;
    logic [CNT_W-1:0] count;
  } list_result_t;

  typedef struct {
    logic [1:0]       fn;
    logic [POS_W-1:0] pos;
    logic [31:0]      val;
    bit               typed;
    list_result_t     res;
  } op_row_t;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} op_phase_t;
  typedef enum {DRAIN_FREE, DRAIN_SPARSE, DRAIN_PERIODIC, DRAIN_HEAVY} drain_mode_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         func_i;
  logic [POS_W-1:0]   position_i;
  logic signed [31:0] item_value_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [3:0]         found_position_o;
  logic [CNT_W-1:0]   entry_count_o;

  // Predicted list contents and length.
  logic [31:0]  list_mem [CAPACITY];
  int           list_len;
  list_result_t pending_results[$];
  int           mismatch_cnt;
  int           burst_left;
  bit           calm;

  // Untyped rows are checked against the predictor only.
  op_row_t directed_ops [19] = '{
    '{FUNC_SEARCH, 5'd0,  32'h0000_0000, 1'b1, '{ST_NOTFOUND, 4'd0, 5'd0}},
    '{FUNC_DELETE, 5'd0,  32'h0000_0000, 1'b1, '{ST_RANGE,    4'd0, 5'd0}},
    '{FUNC_INSERT, 5'd1,  32'h0000_0001, 1'b1, '{ST_RANGE,    4'd0, 5'd0}},
    '{FUNC_UNUSED, 5'd0,  32'h0000_0000, 1'b1, '{ST_RANGE,    4'd0, 5'd0}},
    '{FUNC_INSERT, 5'd0,  32'h8000_0000, 1'b1, '{ST_OK,       4'd0, 5'd1}},
    '{FUNC_INSERT, 5'd1,  32'h7FFF_FFFF, 1'b1, '{ST_OK,       4'd0, 5'd2}},
    '{FUNC_INSERT, 5'd0,  32'hFFFF_FFFF, 1'b1, '{ST_OK,       4'd0, 5'd3}},
    '{FUNC_SEARCH, 5'd31, 32'h8000_0000, 1'b1, '{ST_OK,       4'd1, 5'd3}},
    '{FUNC_SEARCH, 5'd0,  32'h7FFF_FFFF, 1'b1, '{ST_OK,       4'd2, 5'd3}},
    '{FUNC_INSERT, 5'd31, 32'h0000_0005, 1'b1, '{ST_RANGE,    4'd0, 5'd3}},
    '{FUNC_DELETE, 5'd3,  32'h0000_0000, 1'b1, '{ST_RANGE,    4'd0, 5'd3}},
    '{FUNC_INSERT, 5'd3,  32'hFFFF_FFFF, 1'b1, '{ST_OK,       4'd0, 5'd4}},
    '{FUNC_SEARCH, 5'd0,  32'hFFFF_FFFF, 1'b1, '{ST_OK,       4'd0, 5'd4}},
    '{FUNC_DELETE, 5'd0,  32'h1234_5678, 1'b0, '{ST_OK,       4'd0, 5'd0}},
    '{FUNC_SEARCH, 5'd0,  32'hFFFF_FFFF, 1'b0, '{ST_OK,       4'd0, 5'd0}},
    '{FUNC_UNUSED, 5'd31, 32'hFFFF_FFFF, 1'b0, '{ST_OK,       4'd0, 5'd0}},
    '{FUNC_DELETE, 5'd31, 32'h0000_0000, 1'b1, '{ST_RANGE,    4'd0, 5'd3}},
    '{FUNC_SEARCH, 5'd0,  32'h0000_0000, 1'b1, '{ST_NOTFOUND, 4'd0, 5'd3}},
    '{FUNC_DELETE, 5'd2,  32'h0000_0000, 1'b0, '{ST_OK,       4'd0, 5'd0}}
  };

  ordered_list_insert_delete_search u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Applies one operation to the predicted list and returns its result.
  function automatic list_result_t list_apply(logic [1:0] fn, logic [POS_W-1:0] pos,
                                              logic [31:0] val);
    list_result_t r;
    int           i;
    r = '{ST_RANGE, 4'd0, {CNT_W{1'b0}}};
    case (fn)
      FUNC_INSERT: begin
        if (int'(pos) > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[pos[IDX_W-1:0]] = val;
          list_len++;
          r.status = ST_OK;
        end
      end
      FUNC_DELETE: begin
        if (int'(pos) < list_len) begin
          for (i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          r.status = ST_OK;
        end
      end
      FUNC_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_mem[i] == val) begin
            r.status = ST_OK;
            r.found  = i[3:0];
          end
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = list_len[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom_range(0, 6) - 3;  // small values make duplicates
      default: return $urandom;
    endcase
  endfunction

  // Drives one item, waits for acceptance and records its prediction.
  task automatic send_op(input logic [1:0] fn, input logic [POS_W-1:0] pos,
                         input logic [31:0] val, input bit typed, input list_result_t res);
    list_result_t predicted;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    position_i   <= pos;
    item_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predicted = list_apply(fn, pos, val);
    pending_results.push_back(typed ? res : predicted);
  endtask

  // Receiver stall pattern, independent of the sender.
  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_left = 0;
  int          drain_tick = 0;

  always @(posedge clk_i) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      drain_left = $urandom_range(20, 120);
    end else begin
      drain_left--;
    end
    drain_tick++;
    case (drain_mode)
      DRAIN_FREE:     out_stall_i <= 1'b0;
      DRAIN_SPARSE:   out_stall_i <= ($urandom_range(0, 3) == 0);
      DRAIN_PERIODIC: out_stall_i <= (drain_tick % 5 < 2);
      default:        out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected item: status %0d found %0d count %0d", $realtime,
                   status_o, found_position_o, entry_count_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || found_position_o !== want.found ||
            entry_count_o !== want.count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: mismatch: status %0d/%0d found %0d/%0d count %0d/%0d (exp/act)",
                     $realtime, want.status, status_o, want.found, found_position_o,
                     want.count, entry_count_o);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("ordered_list_insert_delete_search_tb: done, errors");
    $finish;
  end

  initial begin
    op_phase_t        phase;
    int               phase_left;
    int               pick;
    logic [1:0]       fn;
    logic [POS_W-1:0] pos;
    logic [31:0]      val;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_INSERT;
    position_i   = '0;
    item_value_i = '0;
    mismatch_cnt = 0;
    burst_left   = 0;
    calm         = 1'b0;
    list_len     = 0;
    for (int i = 0; i < CAPACITY; i++) list_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ops[k])
      send_op(directed_ops[k].fn, directed_ops[k].pos, directed_ops[k].val,
              directed_ops[k].typed, directed_ops[k].res);

    // Start growing so the full list is reached early.
    phase      = PH_GROW;
    phase_left = 60;
    for (int n = 0; n < 800; n++) begin
      if (phase_left == 0) begin
        phase      = op_phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(30, 100);
        calm       = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        fn = FUNC_UNUSED;
      end else begin
        case (phase)
          PH_GROW:   fn = pick < 60 ? FUNC_INSERT : (pick < 75 ? FUNC_DELETE : FUNC_SEARCH);
          PH_SHRINK: fn = pick < 18 ? FUNC_INSERT : (pick < 75 ? FUNC_DELETE : FUNC_SEARCH);
          default:   fn = pick < 40 ? FUNC_INSERT : (pick < 70 ? FUNC_DELETE : FUNC_SEARCH);
        endcase
      end
      pos = POS_W'($urandom_range(0, 31));
      val = $urandom;
      case (fn)
        FUNC_INSERT: begin
          if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, list_len));
          val = pick_value();
        end
        FUNC_DELETE: begin
          if (list_len > 0 && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, list_len - 1));
        end
        FUNC_SEARCH: begin
          if (list_len > 0 && $urandom_range(0, 2) != 0)
            val = list_mem[$urandom_range(0, list_len - 1)];
          else
            val = pick_value();
        end
        default: ;
      endcase
      send_op(fn, pos, val, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("ordered_list_insert_delete_search_tb: done, clean");
    else
      $display("ordered_list_insert_delete_search_tb: done, errors");
    $finish;
  end

endmodule
